[rtl/fsmg_pkg.sv]
// ----------------------------------------------------------------------------
// Falling sand grid package
// Material and mode codes, register indexes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsmg_pkg;

	localparam int CFG_W = 10;

	typedef logic [2:0] mat_t;

	localparam mat_t MAT_EMPTY = 3'd0;
	localparam mat_t MAT_WALL  = 3'd1;
	localparam mat_t MAT_SAND  = 3'd2;
	localparam mat_t MAT_WATER = 3'd3;
	localparam mat_t MAT_GAS   = 3'd4;

	localparam logic [1:0] MODE_WR    = 2'd0;
	localparam logic [1:0] MODE_RD    = 2'd1;
	localparam logic [1:0] MODE_STEP  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [2:0] K_SAND_LAST  = 3'd2;
	localparam logic [2:0] K_FLUID_LAST = 3'd4;

	typedef struct packed {
		logic clr_start;
		logic clr_cells;
		logic clr_marks;
		logic take;
		logic io_wr;
		logic io_rd;
		logic scan_init;
		logic src_rd;
		logic src_load;
		logic tgt_next;
		logic tgt_rd;
		logic swap_dst;
		logic swap_src;
		logic scan_next;
		logic out_set;
		logic out_rd;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic scan_empty;
		logic scan_last;
		logic src_go;
		logic k_over;
		logic tgt_in;
		logic enter;
	} sts_t;

	function automatic logic may_enter(input mat_t mover, input mat_t target);
		logic ok;
		ok = 1'b0;
		case (mover)
			MAT_SAND:  ok = (target == MAT_EMPTY) || (target == MAT_WATER) ||
			                (target == MAT_GAS);
			MAT_WATER: ok = (target == MAT_EMPTY) || (target == MAT_GAS);
			MAT_GAS:   ok = (target == MAT_EMPTY);
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

[rtl/fsmg_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsmg_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/fsmg_ctrl.sv]
// ----------------------------------------------------------------------------
// Falling sand grid controller
// Sequences cell access, clearing sweeps and the update scan.
// ----------------------------------------------------------------------------
module fsmg_ctrl import fsmg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] mode,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output cmd_t       cmd,
	input  sts_t       sts
);

	localparam logic [3:0] S_RST_CLR = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RD      = 4'd2;
	localparam logic [3:0] S_CLR     = 4'd3;
	localparam logic [3:0] S_MCLR    = 4'd4;
	localparam logic [3:0] S_SCAN0   = 4'd5;
	localparam logic [3:0] S_SRC_RD  = 4'd6;
	localparam logic [3:0] S_SRC_CHK = 4'd7;
	localparam logic [3:0] S_TGT_RD  = 4'd8;
	localparam logic [3:0] S_TGT_CHK = 4'd9;
	localparam logic [3:0] S_SWAP    = 4'd10;
	localparam logic [3:0] S_NEXT    = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_RST_CLR: begin
				cmd.clr_cells = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					unique case (mode)
						MODE_WR: begin
							cmd.io_wr   = 1'b1;
							cmd.out_set = 1'b1;
						end
						MODE_RD: begin
							cmd.io_rd = 1'b1;
							state_d   = S_RD;
						end
						MODE_STEP: begin
							cmd.clr_start = 1'b1;
							state_d       = S_MCLR;
						end
						MODE_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d       = S_CLR;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RD: begin
				cmd.out_set = 1'b1;
				cmd.out_rd  = 1'b1;
				state_d     = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_cells = 1'b1;
				if (sts.sweep_last) begin
					cmd.out_set = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_MCLR: begin
				cmd.clr_marks = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_SCAN0;
				end
			end
			S_SCAN0: begin
				if (sts.scan_empty) begin
					cmd.out_set = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SRC_RD;
				end
			end
			S_SRC_RD: begin
				cmd.src_rd = 1'b1;
				state_d    = S_SRC_CHK;
			end
			S_SRC_CHK: begin
				if (sts.src_go) begin
					cmd.src_load = 1'b1;
					state_d      = S_TGT_RD;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_TGT_RD: begin
				if (sts.k_over) begin
					state_d = S_NEXT;
				end else if (sts.tgt_in) begin
					cmd.tgt_rd = 1'b1;
					state_d    = S_TGT_CHK;
				end else begin
					cmd.tgt_next = 1'b1;
				end
			end
			S_TGT_CHK: begin
				if (sts.enter) begin
					cmd.swap_dst = 1'b1;
					state_d      = S_SWAP;
				end else begin
					cmd.tgt_next = 1'b1;
					state_d      = S_TGT_RD;
				end
			end
			S_SWAP: begin
				cmd.swap_src = 1'b1;
				state_d      = S_NEXT;
			end
			S_NEXT: begin
				if (sts.scan_last) begin
					cmd.out_set = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SRC_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_set) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/fsmg_dp.sv]
// ----------------------------------------------------------------------------
// Falling sand grid datapath
// Holds the grid store, the moved marks, the extent registers, the scan
// counters and the target selection for one update step.
// ----------------------------------------------------------------------------
module fsmg_dp import fsmg_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [8:0]       cell_x,
	input  logic [8:0]       cell_y,
	input  mat_t             write_material,
	input  logic             frame_parity,
	output mat_t             read_material,
	input  cmd_t             cmd,
	output sts_t             sts
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = (XW > YW) ? XW : YW;
	localparam int EW    = ((CW > CFG_W) ? CW : CFG_W) + 2;

	logic [CFG_W-1:0] gw_q, gh_q;
	logic [EW-1:0]    uw, uh, cxe, cye, txe, tye, dxe, dye, d1e, d2e, dyv, uhm1;
	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [AW-1:0]    sweep_q, in_addr, src_addr, dst_addr, dst_q, c_wa, m_wa, ra;
	logic [2:0]       k_q, k_lim;
	logic             in_grid, in_grid_q, par_q;
	logic             c_we, m_we, m_wd, re, m_rdata;
	mat_t             m_q, held_q, c_wd, c_rdata, rd_q;

	assign uw  = (EW'(gw_q) > EW'(MAX_WIDTH))  ? EW'(MAX_WIDTH)  : EW'(gw_q);
	assign uh  = (EW'(gh_q) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(gh_q);
	assign cxe = EW'(cell_x);
	assign cye = EW'(cell_y);
	assign in_grid = (cxe < uw) && (cye < uh);
	assign in_addr = {cye[YW-1:0], cxe[XW-1:0]};
	assign src_addr = {y_q, x_q};
	assign uhm1 = uh - EW'(1);

	assign d1e = (x_q[0] ^ y_q[0] ^ par_q) ? EW'(1) : '1;
	assign d2e = (x_q[0] ^ y_q[0] ^ par_q) ? '1 : EW'(1);
	assign dyv = (m_q == MAT_GAS) ? '1 : EW'(1);
	assign k_lim = (m_q == MAT_SAND) ? K_SAND_LAST : K_FLUID_LAST;

	always_comb begin
		case (k_q)
			3'd0: begin dxe = '0;  dye = dyv; end
			3'd1: begin dxe = d1e; dye = dyv; end
			3'd2: begin dxe = d2e; dye = dyv; end
			3'd3: begin dxe = d1e; dye = '0;  end
			3'd4: begin dxe = d2e; dye = '0;  end
			default: begin dxe = '0; dye = '0; end
		endcase
	end

	assign txe      = EW'(x_q) + dxe;
	assign tye      = EW'(y_q) + dye;
	assign dst_addr = {tye[YW-1:0], txe[XW-1:0]};

	assign sts.sweep_last = &sweep_q;
	assign sts.scan_empty = (uw == '0) || (uh == '0);
	assign sts.scan_last  = (EW'(x_q) == uw - EW'(1)) && (y_q == '0);
	assign sts.src_go     = !m_rdata && ((c_rdata == MAT_SAND) || (c_rdata == MAT_WATER) ||
	                        (c_rdata == MAT_GAS));
	assign sts.k_over     = k_q > k_lim;
	assign sts.tgt_in     = !txe[EW-1] && (txe < uw) && !tye[EW-1] && (tye < uh);
	assign sts.enter      = !m_rdata && may_enter(m_q, c_rdata);

	always_comb begin
		c_we = 1'b0;
		c_wa = src_addr;
		c_wd = MAT_EMPTY;
		m_we = 1'b0;
		m_wa = src_addr;
		m_wd = 1'b0;
		if (cmd.clr_cells) begin
			c_we = 1'b1;
			c_wa = sweep_q;
		end else if (cmd.io_wr) begin
			c_we = in_grid && (write_material <= MAT_GAS);
			c_wa = in_addr;
			c_wd = write_material;
		end else if (cmd.swap_dst) begin
			c_we = 1'b1;
			c_wa = dst_q;
			c_wd = m_q;
		end else if (cmd.swap_src) begin
			c_we = 1'b1;
			c_wd = held_q;
		end
		if (cmd.clr_marks) begin
			m_we = 1'b1;
			m_wa = sweep_q;
		end else if (cmd.swap_dst) begin
			m_we = 1'b1;
			m_wa = dst_q;
			m_wd = 1'b1;
		end else if (cmd.swap_src) begin
			m_we = 1'b1;
			m_wd = 1'b1;
		end
	end

	assign re = cmd.io_rd || cmd.src_rd || cmd.tgt_rd;
	assign ra = cmd.io_rd ? in_addr : (cmd.src_rd ? src_addr : dst_addr);

	fsmg_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_cells (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_wa),
		.wdata (c_wd),
		.re    (re),
		.raddr (ra),
		.rdata (c_rdata)
	);

	fsmg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_wa),
		.wdata (m_wd),
		.re    (re),
		.raddr (ra),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q    <= CFG_W'(400);
			gh_q    <= CFG_W'(300);
			sweep_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  gw_q <= cfg_data;
					REG_HEIGHT: gh_q <= cfg_data;
					default:    gw_q <= gw_q;
				endcase
			end
			if (cmd.clr_start) begin
				sweep_q <= '0;
			end else if (cmd.clr_cells || cmd.clr_marks) begin
				sweep_q <= sweep_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			par_q     <= frame_parity;
			in_grid_q <= in_grid;
		end
		if (cmd.scan_init) begin
			x_q <= '0;
			y_q <= uhm1[YW-1:0];
		end else if (cmd.scan_next) begin
			if (EW'(x_q) == uw - EW'(1)) begin
				x_q <= '0;
				y_q <= y_q - YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
		if (cmd.src_load) begin
			m_q <= c_rdata;
			k_q <= '0;
		end else if (cmd.tgt_next) begin
			k_q <= k_q + 3'd1;
		end
		if (cmd.tgt_rd) begin
			dst_q <= dst_addr;
		end
		if (cmd.swap_dst) begin
			held_q <= c_rdata;
		end
		if (cmd.out_set) begin
			rd_q <= (cmd.out_rd && in_grid_q) ? c_rdata : MAT_EMPTY;
		end
	end

	assign read_material = rd_q;

endmodule

[rtl/falling_sand_material_grid_step_top.sv]
// ----------------------------------------------------------------------------
// Falling sand material grid
// Grid of material codes with cell write, cell read, clear and update step.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  mode, cell_x, cell_y, write_material,
//                                 frame_parity
//   out      out_valid/out_stall  read_material, done_res
//   cfg      cfg_we               cfg_index, cfg_data
//
// A write sets its result as it is taken; a read reads the registered RAM
// port and loads its result in S_RD. A clear sweeps every store entry, one
// a cycle; a step sweeps the moved marks the same way and then visits each
// cell in use in S_SRC_RD, S_SRC_CHK and S_NEXT, adding S_TGT_RD and
// S_TGT_CHK per target read, S_TGT_RD per target outside the grid in use
// and when the target list runs out, and S_SWAP for a swap. After reset
// the grid is emptied by the same sweep before the first transfer is taken.
// A stalled result holds; the next item is taken only once it moves on.
// ----------------------------------------------------------------------------
module falling_sand_material_grid_step_top import fsmg_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       mode,
	input  logic [8:0]       cell_x,
	input  logic [8:0]       cell_y,
	input  logic [2:0]       write_material,
	input  logic             frame_parity,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       read_material,
	output logic             done_res,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	fsmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	fsmg_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.write_material (write_material),
		.frame_parity   (frame_parity),
		.read_material  (read_material),
		.cmd            (cmd),
		.sts            (sts)
	);

	assign done_res = 1'b1;

	a_swap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_dst |=> cmd.swap_src)
		else $error("swap not completed");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_RD) |=> cmd.out_set)
		else $error("read result not loaded");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tgt_rd |-> !sts.k_over)
		else $error("target beyond list");

endmodule
